### sv/bsmg_pkg.sv
`timescale 1ns / 1ps
package bsmg_pkg;

  localparam int ValueW = 32;
  localparam int CapW   = 11;
  localparam int CountW = 11;
  localparam int SpanW  = 32;
  localparam int OutW   = 80;

  localparam logic       ADD_STORED = 1'b0;
  localparam logic       ADD_FULL   = 1'b1;

  localparam logic [1:0] SPAN_VALID  = 2'd0;
  localparam logic [1:0] SPAN_EMPTY  = 2'd1;
  localparam logic [1:0] SPAN_SINGLE = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } seq_state_t;

  typedef struct packed {
    logic                add_status;
    logic [CountW-1:0]   stored_count;
    logic [1:0]          span_status;
    logic [SpanW-1:0]    shortest_span;
    logic [SpanW-1:0]    longest_span;
  } result_t;

endpackage

### sv/bounded_set_min_gap_and_range_unit.sv
`timescale 1ns / 1ps
// bounded set with running minimum gap and range
//
// s_tdata carries one signed 32-bit number per request. the number is appended
// to an internal store unless the store already holds min(capacity, STORE_DEPTH)
// numbers, in which case it is rejected and nothing changes.
// every request produces exactly one result on m_tdata: add status, count held,
// span status, smallest gap between any two stored numbers and max minus min.
// cfg_wen/cfg_wdata write the capacity register (reset value 1024); write it
// only while the block is idle.
//
// timing: the new number is compared against every stored number, one memory
// read per cycle through a single shared gap/compare unit. an accepted number
// with numbers already stored passes through the scan, drain and finish
// states; a rejected request or an add to an empty store skips to finish.
// s_tready is high only while the sequencer is idle; one item is in work at a
// time. the result sits in an output register, so a new request is taken while
// it waits; a stalled receiver holds the next item in its final step.
// reset (rst, synchronous) empties the store, restores capacity to 1024 and
// clears the output register. the store memory itself needs no clearing.
module bounded_set_min_gap_and_range_unit #(
  parameter int STORE_DEPTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wen,
  input  logic [bsmg_pkg::CapW-1:0]    cfg_wdata,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // value[31:0]
  input  logic [bsmg_pkg::ValueW-1:0]  s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // add_status[0], stored_count[11:1], span_status[13:12],
  // shortest_span[45:14], longest_span[77:46], zero fill[79:78]
  output logic [bsmg_pkg::OutW-1:0]    m_tdata
);
  import bsmg_pkg::*;

  localparam int AddrW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CntW  = $clog2(STORE_DEPTH + 1);
  localparam int LimW  = (CntW > CapW) ? CntW : CapW;

  seq_state_t state, state_next;

  logic [CapW-1:0]   capacity;
  logic [CntW-1:0]   fill_count;
  logic [ValueW-1:0] smallest_seen;
  logic [ValueW-1:0] largest_seen;
  logic [ValueW-1:0] value;
  logic              reject;
  logic [AddrW-1:0]  rd_idx;
  logic              cmp_en;
  logic              out_valid;
  result_t           out_res;

  logic [LimW-1:0]   limit;
  logic              full_now;
  logic              accept;
  logic              commit;
  logic              last_read;
  logic              mem_re;
  logic [ValueW-1:0] rd_data;
  logic [SpanW-1:0]  least_gap;
  logic [CntW-1:0]   count_new;
  logic [ValueW-1:0] min_new;
  logic [ValueW-1:0] max_new;
  result_t           res_new;

  always_comb begin
    limit = (LimW'(capacity) > LimW'(STORE_DEPTH)) ? LimW'(STORE_DEPTH) : LimW'(capacity);
    full_now = LimW'(fill_count) >= limit;
    last_read = (CntW'(rd_idx) + CntW'(1)) == fill_count;
  end

  always_comb begin
    state_next = state;
    s_tready = 1'b0;
    accept = 1'b0;
    commit = 1'b0;
    mem_re = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        accept = s_tvalid;
        if (s_tvalid) begin
          state_next = (full_now || (fill_count == '0)) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        mem_re = 1'b1;
        if (last_read) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last compare lands in the gap unit here
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid || m_tready) begin
          commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // result built from the state as it stands after this item
  always_comb begin
    count_new = reject ? fill_count : fill_count + CntW'(1);
    if (reject) begin
      min_new = smallest_seen;
      max_new = largest_seen;
    end else if (fill_count == '0) begin
      min_new = value;
      max_new = value;
    end else begin
      min_new = ($signed(value) < $signed(smallest_seen)) ? value : smallest_seen;
      max_new = ($signed(largest_seen) < $signed(value)) ? value : largest_seen;
    end
    res_new.add_status = reject ? ADD_FULL : ADD_STORED;
    res_new.stored_count = CountW'(count_new);
    if (count_new == '0) begin
      res_new.span_status = SPAN_EMPTY;
      res_new.shortest_span = '0;
      res_new.longest_span = '0;
    end else if (count_new == CntW'(1)) begin
      res_new.span_status = SPAN_SINGLE;
      res_new.shortest_span = '0;
      res_new.longest_span = '0;
    end else begin
      res_new.span_status = SPAN_VALID;
      res_new.shortest_span = least_gap;
      res_new.longest_span = max_new - min_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CapW'(1024);
      fill_count <= '0;
      smallest_seen <= '0;
      largest_seen <= '0;
      cmp_en <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wen) begin
        capacity <= cfg_wdata;
      end
      cmp_en <= mem_re;
      if (commit && !reject) begin
        fill_count <= count_new;
        smallest_seen <= min_new;
        largest_seen <= max_new;
      end
      if (commit) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      value <= s_tdata;
      reject <= full_now;
      rd_idx <= '0;
    end else if (mem_re && !last_read) begin
      rd_idx <= rd_idx + AddrW'(1);
    end
    if (commit) begin
      out_res <= res_new;
    end
  end

  bsmg_store #(
    .Depth (STORE_DEPTH),
    .AddrW (AddrW)
  ) u_store (
    .clk   (clk),
    .we    (commit && !reject),
    .waddr (fill_count[AddrW-1:0]),
    .wdata (value),
    .re    (mem_re),
    .raddr (rd_idx),
    .rdata (rd_data)
  );

  bsmg_gap_unit u_gap (
    .clk          (clk),
    .rst          (rst),
    .en           (cmp_en),
    .new_value    (value),
    .stored_value (rd_data),
    .least_gap    (least_gap)
  );

  assign m_tvalid = out_valid;
  assign m_tdata = {2'b00, out_res.longest_span, out_res.shortest_span,
                    out_res.span_status, out_res.stored_count, out_res.add_status};

endmodule

### sv/bsmg_store.sv
`timescale 1ns / 1ps
module bsmg_store #(
  parameter int Depth = 1024,
  parameter int AddrW = 10
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AddrW-1:0]           waddr,
  input  logic [bsmg_pkg::ValueW-1:0] wdata,
  input  logic                       re,
  input  logic [AddrW-1:0]           raddr,
  output logic [bsmg_pkg::ValueW-1:0] rdata
);
  import bsmg_pkg::*;

  logic [ValueW-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/bsmg_gap_unit.sv
`timescale 1ns / 1ps
module bsmg_gap_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic [bsmg_pkg::ValueW-1:0] new_value,
  input  logic [bsmg_pkg::ValueW-1:0] stored_value,
  output logic [bsmg_pkg::SpanW-1:0]  least_gap
);
  import bsmg_pkg::*;

  logic [SpanW-1:0] gap;
  logic             new_below;

  // wraparound subtract is exact for the absolute difference of two signed words
  always_comb begin
    new_below = $signed(new_value) < $signed(stored_value);
    gap = new_below ? (stored_value - new_value) : (new_value - stored_value);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      least_gap <= '1;
    end else if (en && (gap < least_gap)) begin
      least_gap <= gap;
    end
  end

endmodule

### sim/span_result_checker.sv
`timescale 1ns / 1ps
module span_result_checker
  import bsmg_pkg::*;
#(
  parameter int STORE_DEPTH = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wen,
  input  logic [CapW-1:0]   cfg_wdata,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [ValueW-1:0] s_tdata,
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [OutW-1:0]   m_tdata,
  input  logic              run_done,
  output int                mismatches
);

  logic [ValueW-1:0] kept_values [STORE_DEPTH];
  int unsigned       kept_n;
  logic [ValueW-1:0] kept_lo;
  logic [ValueW-1:0] kept_hi;
  logic [SpanW-1:0]  tightest_gap;
  logic [CapW-1:0]   capacity;
  result_t           spans_due [$];
  int                errs = 0;
  int                n_results = 0;
  bit                leftover_checked = 0;

  assign mismatches = errs;

  function automatic logic [SpanW-1:0] value_gap(logic [ValueW-1:0] a, logic [ValueW-1:0] b);
    return ($signed(a) < $signed(b)) ? b - a : a - b;
  endfunction

  // result layout on m_tdata differs from the packed struct order
  function automatic result_t unpack_result(logic [OutW-1:0] d);
    result_t r;
    r.add_status    = d[0];
    r.stored_count  = d[11:1];
    r.span_status   = d[13:12];
    r.shortest_span = d[45:14];
    r.longest_span  = d[77:46];
    return r;
  endfunction

  task automatic predict_insert(input logic [ValueW-1:0] v);
    int unsigned      lim;
    logic [SpanW-1:0] g;
    result_t          r;
    lim = (capacity > STORE_DEPTH) ? STORE_DEPTH : capacity;
    if (kept_n >= lim) begin
      r.add_status = ADD_FULL;
    end else begin
      r.add_status = ADD_STORED;
      for (int unsigned i = 0; i < kept_n; i++) begin
        g = value_gap(v, kept_values[i]);
        if (g < tightest_gap) tightest_gap = g;
      end
      if (kept_n == 0) begin
        kept_lo = v;
        kept_hi = v;
      end else begin
        if ($signed(v) < $signed(kept_lo)) kept_lo = v;
        if ($signed(kept_hi) < $signed(v)) kept_hi = v;
      end
      kept_values[kept_n] = v;
      kept_n++;
    end
    r.stored_count = kept_n[CountW-1:0];
    r.shortest_span = '0;
    r.longest_span = '0;
    if (kept_n == 0) begin
      r.span_status = SPAN_EMPTY;
    end else if (kept_n == 1) begin
      r.span_status = SPAN_SINGLE;
    end else begin
      r.span_status = SPAN_VALID;
      r.shortest_span = tightest_gap;
      r.longest_span = kept_hi - kept_lo;
    end
    spans_due = {spans_due, r};
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      errs++;
      if (errs <= 10)
        $display("result %0d %s: expected %0h, got %0h", n_results, name, want, got);
    end
  endtask

  task automatic check_result(input result_t want, input result_t got);
    check_field("add_status", want.add_status, got.add_status);
    check_field("stored_count", want.stored_count, got.stored_count);
    check_field("span_status", want.span_status, got.span_status);
    check_field("shortest_span", want.shortest_span, got.shortest_span);
    check_field("longest_span", want.longest_span, got.longest_span);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      kept_n = 0;
      kept_lo = '0;
      kept_hi = '0;
      tightest_gap = '1;
      capacity = CapW'(1024);
      spans_due.delete();
    end else begin
      if (cfg_wen) capacity = cfg_wdata;
      // retire the result first so a stray one cannot pair with a fresh request
      if (m_tvalid && m_tready) begin
        if (spans_due.size() == 0) begin
          errs++;
          if (errs <= 10) $display("result %0d arrived with no request pending", n_results);
        end else begin
          check_result(spans_due.pop_front(), unpack_result(m_tdata));
        end
        n_results++;
      end
      if (s_tvalid && s_tready) predict_insert(s_tdata);
      if (run_done && !leftover_checked) begin
        leftover_checked = 1;
        if (spans_due.size() != 0) begin
          if (errs < 10) $display("%0d results never arrived", spans_due.size());
          errs += spans_due.size();
        end
      end
    end
  end

endmodule

### sim/bounded_set_min_gap_and_range_unit_tb.sv
`timescale 1ns / 1ps
module bounded_set_min_gap_and_range_unit_tb;
  import bsmg_pkg::*;

  localparam int STORE_DEPTH = 1024;
  localparam int RANDOM_ITEMS = 570;
  localparam logic [ValueW-1:0] MOST_NEGATIVE = 32'h8000_0000;
  localparam logic [ValueW-1:0] MOST_POSITIVE = 32'h7fff_ffff;
  localparam logic [CapW-1:0] CAP_ALL_ONES = 11'h7ff;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_wen = 1'b0;
  logic [CapW-1:0]   cfg_wdata = '0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [ValueW-1:0] s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OutW-1:0]   m_tdata;
  logic              run_done = 1'b0;
  int                mismatches;

  int unsigned tx_gap_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned n_sent = 0;
  int unsigned n_got = 0;
  int unsigned held_est = 0;
  int unsigned cap_est = 1024;

  always #4 clk = ~clk;

  bounded_set_min_gap_and_range_unit #(
    .STORE_DEPTH(STORE_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  span_result_checker #(
    .STORE_DEPTH(STORE_DEPTH)
  ) i_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .run_done  (run_done),
    .mismatches(mismatches)
  );

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_stall_pct);
    if (!rst && m_tvalid && m_tready) n_got <= n_got + 1;
  end

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        tx_gap_pct = 0;
        rx_stall_pct = 0;
      end
      IDLE_SENDER: begin
        tx_gap_pct = 54;
        rx_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        tx_gap_pct = 0;
        rx_stall_pct = 54;
      end
      default: begin
        tx_gap_pct = 24;
        rx_stall_pct = 24;
      end
    endcase
  endtask

  // valid stays high into the next request when no gap is drawn
  task automatic offer(input logic [ValueW-1:0] v);
    int unsigned lim;
    while ($urandom_range(99) < tx_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= v;
    do @(posedge clk); while (!s_tready);
    n_sent++;
    lim = (cap_est > STORE_DEPTH) ? STORE_DEPTH : cap_est;
    if (held_est < lim) held_est++;
  endtask

  // hold off until every request has its result, then let the block settle
  task automatic drain;
    s_tvalid <= 1'b0;
    do @(posedge clk); while (n_got != n_sent);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CapW-1:0] c);
    drain();
    cfg_wdata <= c;
    cfg_wen <= 1'b1;
    @(posedge clk);
    cfg_wen <= 1'b0;
    cap_est = c;
  endtask

  function automatic logic [ValueW-1:0] pick_value(input logic [ValueW-1:0] center);
    if ($urandom_range(9) < 6) return $urandom;
    return center + $urandom_range(0, 2097151) - 32'd1048576;
  endfunction

  initial begin
    int unsigned      rand_sent;
    int unsigned      phase;
    int unsigned      n_items;
    int unsigned      lim;
    logic [CapW-1:0]  cap_pick;
    logic [ValueW-1:0] center;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: zero capacity, single entry, small spans, capacity at or below count
    set_idling(IDLE_NONE);
    write_capacity('0);
    offer(MOST_NEGATIVE);
    offer(MOST_POSITIVE);
    offer('0);
    offer('1);
    write_capacity(CapW'(1));
    offer(32'd100);
    offer(-32'sd5);
    write_capacity(CAP_ALL_ONES);
    offer(32'd103);
    offer(32'd97);
    offer(32'd101);
    write_capacity(CapW'(2));
    offer(32'd50);
    write_capacity(CapW'(4));
    offer(32'd7);

    rand_sent = 0;
    phase = 0;
    while (rand_sent < RANDOM_ITEMS) begin
      case ($urandom_range(9))
        0: cap_pick = CAP_ALL_ONES;
        1: cap_pick = CapW'(1024);
        2: cap_pick = CapW'($urandom_range(held_est));
        default: cap_pick = CapW'(held_est + $urandom_range(1, 40));
      endcase
      write_capacity(cap_pick);
      set_idling(idle_mode_t'(phase % 4));
      lim = (cap_pick > STORE_DEPTH) ? STORE_DEPTH : cap_pick;
      if (cap_pick >= 1024)
        n_items = $urandom_range(15, 40);
      else if (lim > held_est)
        n_items = lim - held_est + $urandom_range(0, 4);
      else
        n_items = $urandom_range(3, 8);
      center = $urandom;
      repeat (n_items) begin
        offer(pick_value(center));
        rand_sent++;
      end
      phase++;
    end

    // widest possible span, then a repeated value for a zero gap
    write_capacity(CAP_ALL_ONES);
    set_idling(IDLE_BOTH);
    offer(MOST_NEGATIVE);
    offer(MOST_POSITIVE);
    offer(32'd100);

    drain();
    repeat (20) @(posedge clk);
    run_done <= 1'b1;
    repeat (2) @(posedge clk);
    if (mismatches == 0) begin
      $display("bounded_set_min_gap_and_range_unit: match");
    end else begin
      $display("bounded_set_min_gap_and_range_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("bounded_set_min_gap_and_range_unit: mismatch");
    $finish;
  end

endmodule

### files.f
sv/bsmg_pkg.sv
sv/bsmg_store.sv
sv/bsmg_gap_unit.sv
sv/bounded_set_min_gap_and_range_unit.sv
sim/span_result_checker.sv
sim/bounded_set_min_gap_and_range_unit_tb.sv
